// ----- rtl/core/hff_pkg.sv -----
package hff_pkg;

    // Field limits
    localparam int unsigned MAX_CHARS = 64;
    localparam int unsigned MAX_PREC  = 62;

    // Word widths
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned PREC_W  = 6;
    localparam int unsigned WIDTH_W = 7;
    localparam int unsigned POS_W   = 7;   // holds 0..MAX_CHARS
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X_LOWER = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UPPER = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CH_A_UPPER = 8'h41;

    // One conversion request as received
    typedef struct packed {
        logic [WIDTH_W-1:0] field_width;
        logic [PREC_W-1:0]  precision;
        logic               has_precision;
        logic               zero_pad;
        logic               alt_form;
        logic               left_justify;
        logic               uppercase;
        logic [VAL_W-1:0]   value;
    } conv_req_t;

    // Decoded conversion: character positions of each region
    typedef struct packed {
        logic               nonempty;
        logic [VAL_W-1:0]   value;
        logic               uppercase;
        logic [POS_W-1:0]   body_start;   // first prefix/digit position
        logic [POS_W-1:0]   digit_start;  // first digit position
        logic [POS_W-1:0]   body_end;     // one past the last digit
        logic [POS_W-1:0]   total;        // characters in the field
    } conv_job_t;

    // Hex digit to ASCII
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {4'd0, nib};
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + ext;
        end else if (upper) begin
            hex_char = CH_A_UPPER + ext - 8'd10;
        end else begin
            hex_char = CH_A_LOWER + ext - 8'd10;
        end
    endfunction

endpackage

// ----- rtl/core/hff_decode.sv -----
module hff_decode
    import hff_pkg::*;
(
    input  conv_req_t req,
    output conv_job_t job
);

    logic [WIDTH_W-1:0] width_sat;
    logic [PREC_W-1:0]  prec_sat;
    logic [3:0]         nib_cnt;
    logic [3:0]         hex_len;
    logic [POS_W-1:0]   ndig_prec;
    logic [POS_W-1:0]   ndig;
    logic [1:0]         pre_len;
    logic [POS_W-1:0]   pre_ext;
    logic [POS_W-1:0]   body;
    logic [POS_W-1:0]   pad;
    logic               value_nz;
    logic               zpad_on;

    // Saturate width and precision
    assign width_sat = (req.field_width > WIDTH_W'(MAX_CHARS)) ? WIDTH_W'(MAX_CHARS)
                                                                : req.field_width;
    assign prec_sat  = (req.precision > PREC_W'(MAX_PREC)) ? PREC_W'(MAX_PREC)
                                                            : req.precision;

    // Significant nibble count, at least one
    always_comb begin
        nib_cnt = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if ((req.value >> (4 * i)) != '0) begin
                nib_cnt = 4'(i + 1);
            end
        end
    end

    assign value_nz = (req.value != '0);
    // zero value with zero precision prints no digits
    assign hex_len  = (req.has_precision && prec_sat == '0 && !value_nz) ? 4'd0 : nib_cnt;

    assign ndig_prec = (req.has_precision && POS_W'(prec_sat) > POS_W'(hex_len))
                       ? POS_W'(prec_sat) : POS_W'(hex_len);
    assign pre_len   = (req.alt_form && value_nz) ? 2'd2 : 2'd0;
    assign pre_ext   = POS_W'(pre_len);

    // Zero padding only without precision and right justified
    assign zpad_on = req.zero_pad && !req.has_precision && !req.left_justify
                     && (width_sat > pre_ext + ndig_prec);
    assign ndig    = zpad_on ? (width_sat - pre_ext) : ndig_prec;
    assign body    = pre_ext + ndig;
    assign pad     = (width_sat > body) ? (width_sat - body) : '0;

    always_comb begin
        job.value       = req.value;
        job.uppercase   = req.uppercase;
        job.body_start  = req.left_justify ? '0 : pad;
        job.digit_start = job.body_start + pre_ext;
        job.body_end    = job.body_start + body;
        job.total       = pad + body;
        job.nonempty    = (job.total != '0);
    end

endmodule

// ----- rtl/core/hff_emitter.sv -----
module hff_emitter
    import hff_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  conv_job_t           job,
    output logic                job_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] char_out
    output logic                m_tlast    // last_char
);

    conv_job_t         job_reg;
    logic              busy_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              emit;
    logic              is_last;
    logic              load;
    logic [POS_W-1:0]  dig_k;
    logic [CHAR_W-1:0] cur_char;

    // Output register free, current character goes out
    assign emit      = busy_reg && (!out_valid_reg || m_tready);
    assign is_last   = (pos_reg == job_reg.total - POS_W'(1));
    assign job_ready = !busy_reg || (emit && is_last);
    assign load      = job_valid && job_ready && job.nonempty;
    assign pos_next  = pos_reg + POS_W'(1);

    // Character at the current position
    assign dig_k = job_reg.body_end - POS_W'(1) - pos_reg;
    always_comb begin
        if (pos_reg < job_reg.body_start || pos_reg >= job_reg.body_end) begin
            cur_char = CH_SPACE;
        end else if (pos_reg < job_reg.digit_start) begin
            if (pos_reg == job_reg.body_start) begin
                cur_char = CH_ZERO;
            end else begin
                cur_char = job_reg.uppercase ? CH_X_UPPER : CH_X_LOWER;
            end
        end else if (dig_k < POS_W'(8)) begin
            cur_char = hex_char(job_reg.value[4*dig_k[2:0] +: 4], job_reg.uppercase);
        end else begin
            cur_char = CH_ZERO;
        end
    end

    // Job slot and position counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end else if (emit) begin
                busy_reg <= !is_last;
                pos_reg  <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_char_reg <= cur_char;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg < job_reg.total))
        else $error("position beyond field length");

    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (busy_reg && pos_reg == '0))
        else $error("new job did not start at position zero");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && is_last && !load) |=> !busy_reg)
        else $error("job slot still busy after last word");

    a_no_empty_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.total != '0))
        else $error("empty conversion held in job slot");
`endif

endmodule

// ----- rtl/core/hex_field_formatter.sv -----
// Path: input register, emitter job register, output register, then m_tdata.
// Throughput: one character per cycle unless m_tready stalls; a conversion holds
// the character emitter for its 1 to 64 characters, and one that prints nothing
// skips it. The single output character port sets the rate.
// Reset: aresetn synchronous, active low; clears all valid flags.
module hex_field_formatter
    import hff_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [31:0] value, [32] uppercase, [33] left_justify, [34] alt_form,
    // [35] zero_pad, [36] has_precision, [42:37] precision, [49:43] field_width
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] char_out
    output logic                m_tlast    // last_char
);

    localparam int unsigned REQ_W = $bits(conv_req_t);

    conv_req_t req_reg;
    logic      req_valid_reg;
    conv_job_t job;
    logic      job_ready;
    logic      req_move;

    // Input register
    assign req_move = req_valid_reg && job_ready;
    assign s_tready = !req_valid_reg || req_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_tready) begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= conv_req_t'(s_tdata[REQ_W-1:0]);
        end
    end

    hff_decode u_decode (
        .req (req_reg),
        .job (job)
    );

    hff_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (req_valid_reg),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
